>>> sv/lzwe_pkg.sv
package lzwe_pkg;

  // Alphabet and code constants
  localparam int unsigned SYM_W      = 6;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CODE_W     = 12;
  localparam int unsigned BASE_CODES = 39;

  localparam logic [BYTE_W-1:0] CH_DIGIT_LO = 8'd48;
  localparam logic [BYTE_W-1:0] CH_DIGIT_HI = 8'd57;
  localparam logic [BYTE_W-1:0] CH_UPPER_LO = 8'd65;
  localparam logic [BYTE_W-1:0] CH_UPPER_HI = 8'd90;
  localparam logic [BYTE_W-1:0] CH_COMMA    = 8'd44;
  localparam logic [BYTE_W-1:0] CH_PERIOD   = 8'd46;
  localparam logic [BYTE_W-1:0] CH_NEWLINE  = 8'd10;

  localparam logic [SYM_W-1:0] SYM_UPPER_BASE = 6'd10;
  localparam logic [SYM_W-1:0] SYM_COMMA      = 6'd36;
  localparam logic [SYM_W-1:0] SYM_PERIOD     = 6'd37;
  localparam logic [SYM_W-1:0] SYM_NEWLINE    = 6'd38;

  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] code;
  } sym_map_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEARCH,
    ST_MISS,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    RES_BAD,
    RES_MISS,
    RES_FLUSH
  } res_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     cap;
    logic     srch_init;
    logic     srch_step;
    logic     take_hit;
    logic     start_pfx;
    logic     add_entry;
    logic     clear;
    logic     out_load;
    res_sel_t out_sel;
  } lzwe_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bad;
    logic last;
    logic pfx_valid;
    logic hit;
    logic miss;
    logic out_free;
  } lzwe_sts_t;

  // Map a byte onto the alphabet
  function automatic sym_map_t map_byte(input logic [BYTE_W-1:0] b);
    sym_map_t m;
    m.ok   = 1'b1;
    m.code = '0;
    if (b >= CH_DIGIT_LO && b <= CH_DIGIT_HI) begin
      m.code = SYM_W'(b - CH_DIGIT_LO);
    end else if (b >= CH_UPPER_LO && b <= CH_UPPER_HI) begin
      m.code = SYM_W'(b - CH_UPPER_LO) + SYM_UPPER_BASE;
    end else if (b == CH_COMMA) begin
      m.code = SYM_COMMA;
    end else if (b == CH_PERIOD) begin
      m.code = SYM_PERIOD;
    end else if (b == CH_NEWLINE) begin
      m.code = SYM_NEWLINE;
    end else begin
      m.ok = 1'b0;
    end
    return m;
  endfunction

endpackage

>>> sv/lzwe_ram.sv
module lzwe_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lzwe_ctrl.sv
module lzwe_ctrl
  import lzwe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  lzwe_sts_t sts,
  output lzwe_cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (sts.bad) begin
          if (sts.out_free) begin
            state_nxt = (sts.last && sts.pfx_valid) ? ST_FLUSH : ST_IDLE;
          end
        end else if (!sts.pfx_valid) begin
          state_nxt = sts.last ? ST_FLUSH : ST_IDLE;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.hit) begin
          state_nxt = sts.last ? ST_FLUSH : ST_IDLE;
        end else if (sts.miss) begin
          state_nxt = ST_MISS;
        end
      end
      ST_MISS: begin
        if (sts.out_free) state_nxt = sts.last ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    cmd.out_sel = RES_BAD;
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        cmd.cap = in_valid;
      end
      ST_DISPATCH: begin
        if (sts.bad) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_sel  = RES_BAD;
            // bad final byte with nothing pending still ends the message
            cmd.clear    = sts.last && !sts.pfx_valid;
          end
        end else if (!sts.pfx_valid) begin
          cmd.start_pfx = 1'b1;
        end else begin
          cmd.srch_init = 1'b1;
        end
      end
      ST_SEARCH: begin
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
        end else if (!sts.miss) begin
          cmd.srch_step = 1'b1;
        end
      end
      ST_MISS: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = RES_MISS;
          cmd.add_entry = 1'b1;
          cmd.start_pfx = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = RES_FLUSH;
          cmd.clear    = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sv/lzwe_dp.sv
module lzwe_dp
  import lzwe_pkg::*;
#(
  parameter int unsigned DICT_SIZE = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] in_symbol,
  input  logic              in_end_of_input,
  input  lzwe_cmd_t         cmd,
  output lzwe_sts_t         sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_code,
  output logic              out_bad_symbol,
  output logic              out_final_code
);

  localparam int unsigned CW = $clog2(DICT_SIZE);
  localparam int unsigned KW = CW + SYM_W;
  localparam logic [CW:0] BASE_CNT = (CW+1)'(BASE_CODES);
  localparam logic [CW:0] DICT_CNT = (CW+1)'(DICT_SIZE);

  sym_map_t          map;
  logic [SYM_W-1:0]  sym_r;
  logic              bad_r;
  logic              last_r;
  logic [CW-1:0]     prefix_r;
  logic              pfx_valid_r;
  logic [CW:0]       nf_r;
  logic [CW:0]       cnt_r;
  logic              pend_r;
  logic [CW-1:0]     rd_addr_r;
  logic [KW-1:0]     key;
  logic [KW-1:0]     rdata;
  logic              hit;
  logic              we;
  logic              out_valid_r;
  logic [CODE_W-1:0] out_code_r;
  logic              out_bad_r;
  logic              out_final_r;
  logic              out_free;

  assign map      = map_byte(in_symbol);
  assign key      = {prefix_r, sym_r};
  assign hit      = pend_r && (rdata == key);
  assign out_free = !out_valid_r || !out_stall;
  assign we       = cmd.add_entry && (nf_r < DICT_CNT);

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      sym_r  <= map.code;
      bad_r  <= !map.ok;
      last_r <= in_end_of_input;
    end
  end

  // Pending prefix and dictionary fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r    <= '0;
      pfx_valid_r <= 1'b0;
      nf_r        <= BASE_CNT;
    end else begin
      if (cmd.take_hit) begin
        prefix_r <= rd_addr_r;
      end else if (cmd.start_pfx) begin
        prefix_r    <= CW'(sym_r);
        pfx_valid_r <= 1'b1;
      end
      if (we) begin
        nf_r <= nf_r + 1'b1;
      end
      // flush wins: the message ends with a fresh dictionary
      if (cmd.clear) begin
        prefix_r    <= '0;
        pfx_valid_r <= 1'b0;
        nf_r        <= BASE_CNT;
      end
    end
  end

  // Scan the dictionary one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= BASE_CNT;
      pend_r <= 1'b0;
    end else if (cmd.srch_init) begin
      cnt_r  <= BASE_CNT;
      pend_r <= 1'b0;
    end else if (cmd.srch_step && cnt_r < nf_r) begin
      cnt_r  <= cnt_r + 1'b1;
      pend_r <= 1'b1;
    end else begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= cnt_r[CW-1:0];
  end

  lzwe_ram #(
    .WIDTH (KW),
    .DEPTH (DICT_SIZE)
  ) u_dict (
    .clk   (clk),
    .we    (we),
    .waddr (nf_r[CW-1:0]),
    .wdata (key),
    .raddr (cnt_r[CW-1:0]),
    .rdata (rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        RES_BAD: begin
          out_code_r  <= '0;
          out_bad_r   <= 1'b1;
          out_final_r <= last_r && !pfx_valid_r;
        end
        RES_MISS: begin
          out_code_r  <= CODE_W'(prefix_r);
          out_bad_r   <= 1'b0;
          out_final_r <= 1'b0;
        end
        RES_FLUSH: begin
          out_code_r  <= CODE_W'(prefix_r);
          out_bad_r   <= 1'b0;
          out_final_r <= 1'b1;
        end
        default: begin
          out_code_r  <= '0;
          out_bad_r   <= 1'b0;
          out_final_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code       = out_code_r;
  assign out_bad_symbol = out_bad_r;
  assign out_final_code = out_final_r;

  // Status to the controller
  always_comb begin
    sts.bad       = bad_r;
    sts.last      = last_r;
    sts.pfx_valid = pfx_valid_r;
    sts.hit       = hit;
    sts.miss      = !hit && (cnt_r >= nf_r);
    sts.out_free  = out_free;
  end

endmodule

>>> sv/lzw_encoder_alnum_alphabet.sv
// LZW encoder over a 39-symbol alphabet (digits, capitals, comma, period,
// newline). One byte enters per item; each emitted code leaves at 12 bits.
// A byte outside the alphabet gives one result with bad_symbol set; an item
// with end_of_input set flushes the pending code, marks it final_code and
// starts a fresh dictionary. An item that only starts a prefix or is a bad
// byte needs no search; otherwise the dictionary RAM is scanned linearly
// through its single read port, one entry per cycle, until a hit or the
// last filled entry. end_of_input adds a flush step. Results sit in an
// output register, so a stalled output does not hold up the scan; it only
// holds the step that emits.
// No clearing pass after reset is needed.
module lzw_encoder_alnum_alphabet
  import lzwe_pkg::*;
#(
  parameter int unsigned DICT_SIZE = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_symbol,
  input  logic              in_end_of_input,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_code,
  output logic              out_bad_symbol,
  output logic              out_final_code
);

  lzwe_cmd_t cmd;
  lzwe_sts_t sts;

  lzwe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzwe_dp #(
    .DICT_SIZE (DICT_SIZE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_symbol       (in_symbol),
    .in_end_of_input (in_end_of_input),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code        (out_code),
    .out_bad_symbol  (out_bad_symbol),
    .out_final_code  (out_final_code)
  );

endmodule
